// ===== sv/frmon_pkg.sv =====
// ----------------------------------------------------------------------------
// frmon_pkg: shared types and constants for the frequency / rate monitor
// Widths, reset values and the beat type handed from front to back end.
// ----------------------------------------------------------------------------
`default_nettype none
package frmon_pkg;
  localparam int CountBits = 16;
  localparam int FracBits  = 8;
  localparam int FsBits    = 16;
  localparam int FreqBits  = 24;
  localparam int RateBits  = 32;
  localparam int TsBits    = 32;
  // numerator widths of the two divisions
  localparam int FNumBits  = FsBits + FracBits;           // Fs << frac
  localparam int RNumBits  = FreqBits + FsBits + 1;       // diff * Fs * 2
  localparam int DenBits   = CountBits + 1;               // count sum
  localparam int QBits     = RNumBits;                    // widest quotient
  localparam int QCntBits  = $clog2(QBits + 1);

  localparam logic [FsBits-1:0]   FsReset   = 16'd16000;
  localparam logic [FreqBits-1:0] LowReset  = 24'd12544;
  localparam logic [FreqBits-1:0] HighReset = 24'd14080;
  localparam logic [RateBits-1:0] RateReset = 32'd25600;

  localparam logic [1:0] RegFs   = 2'd0;
  localparam logic [1:0] RegLow  = 2'd1;
  localparam logic [1:0] RegHigh = 2'd2;
  localparam logic [1:0] RegRate = 2'd3;

  typedef struct packed {
    logic [CountBits-1:0] count;   // already clamped to >= 1
    logic [TsBits-1:0]    ts;
  } frmon_beat_t;
endpackage
`default_nettype wire

// ===== sv/frmon_front.sv =====
// ----------------------------------------------------------------------------
// frmon_front: input stage and two-entry queue
// Clamps a zero count to one and buffers beats for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module frmon_front import frmon_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CountBits-1:0] in_period_count,
  input  wire logic [TsBits-1:0]    in_timestamp,
  output logic                      q_valid,
  input  wire logic                 q_pop,
  output frmon_beat_t               q_beat
);
  frmon_beat_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_beat   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].count <= (in_period_count == '0) ? CountBits'(1) : in_period_count;
      mem_r[wp_r].ts    <= in_timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/frmon_div.sv =====
// ----------------------------------------------------------------------------
// frmon_div: restoring divider, one quotient bit per cycle
// Divides a QBits numerator by a DenBits divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module frmon_div import frmon_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [QBits-1:0]   num,
  input  wire logic [DenBits-1:0] den,
  output logic                    done,
  output logic [QBits-1:0]        quo
);
  logic [QBits-1:0]    q_r;
  logic [DenBits:0]    rem_r;
  logic [DenBits-1:0]  den_r;
  logic [QCntBits-1:0] n_r;
  logic                busy_r, done_r;
  logic [DenBits:0]    trial;
  logic                ge;

  assign trial = {rem_r[DenBits-1:0], q_r[QBits-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num; rem_r <= '0; den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
      q_r   <= {q_r[QBits-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; n_r <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_r <= !start && busy_r && (n_r == QCntBits'(1));
      if (start) begin
        busy_r <= 1'b1; n_r <= QCntBits'(QBits);
      end else if (busy_r) begin
        n_r <= n_r - 1'b1;
        if (n_r == QCntBits'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/frmon_back.sv =====
// ----------------------------------------------------------------------------
// frmon_back: frequency and rate computation, limit checks, output register
// Sequencer around one shared divider and one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module frmon_back import frmon_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire frmon_beat_t         q_beat,
  input  wire logic [FsBits-1:0]   fs,
  input  wire logic [FreqBits-1:0] f_low,
  input  wire logic [FreqBits-1:0] f_high,
  input  wire logic [RateBits-1:0] r_limit,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_stable,
  output logic                     out_stability_changed,
  output logic [FreqBits-1:0]      out_frequency_q8,
  output logic [RateBits-1:0]      out_rocof_q8,
  output logic [TsBits-1:0]        out_event_time
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_FDIV = 6'b000010, S_MUL  = 6'b000100,
    S_RDIV = 6'b001000, S_CHK  = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t state_r;
  frmon_beat_t beat_r;
  logic [FreqBits-1:0]  freq_r, prev_f_r;
  logic [CountBits-1:0] prev_c_r;
  logic [RateBits-1:0]  rate_r;
  logic                 stab_state_r, first_r;
  logic                 div_start, div_done;
  logic [QBits-1:0]     div_num, div_quo;
  logic [DenBits-1:0]   div_den, csum;
  logic [FreqBits-1:0]  diff;
  logic [RNumBits-2:0]  prod;
  logic                 stab;
  logic                 out_take;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign csum     = {1'b0, beat_r.count} + {1'b0, prev_c_r};
  assign diff     = (freq_r >= prev_f_r) ? freq_r - prev_f_r : prev_f_r - freq_r;
  // diff * Fs at full width; the doubling is the shift into the divider
  assign prod     = (RNumBits-1)'(diff) * (RNumBits-1)'(fs);
  assign out_take = (state_r == S_CHK) && (!out_valid || out_ready);

  always_comb begin
    div_start = 1'b0;
    div_num   = QBits'({fs, {FracBits{1'b0}}});
    div_den   = DenBits'(q_beat.count == '0 ? CountBits'(1) : q_beat.count);
    if (q_pop) div_start = 1'b1;
    if (state_r == S_MUL) begin
      div_start = 1'b1;
      div_num   = {prod, 1'b0};
      div_den   = (csum == '0) ? DenBits'(1) : csum;
    end
  end

  frmon_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign stab = first_r || ((freq_r > f_low) && (freq_r < f_high) && (rate_r < r_limit));

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (q_pop) beat_r <= q_beat;
      S_FDIV: if (div_done) begin
        freq_r <= (div_quo[QBits-1:FreqBits] != '0) ? '1 : div_quo[FreqBits-1:0];
        rate_r <= '0;
      end
      S_RDIV: if (div_done)
        rate_r <= (div_quo[QBits-1:RateBits] != '0) ? '1 : div_quo[RateBits-1:0];
      S_CHK: if (out_take) begin
        out_stable            <= stab;
        out_stability_changed <= stab != stab_state_r;
        out_frequency_q8      <= freq_r;
        out_rocof_q8          <= rate_r;
        out_event_time        <= beat_r.ts;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid <= 1'b0; first_r <= 1'b1;
      stab_state_r <= 1'b1; prev_f_r <= '0; prev_c_r <= '0;
    end else begin
      if (out_take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (q_pop) state_r <= S_FDIV;
        S_FDIV: if (div_done) state_r <= first_r ? S_CHK : S_MUL;
        S_MUL:  state_r <= S_RDIV;
        S_RDIV: if (div_done) state_r <= S_CHK;
        S_CHK:  if (out_take) begin
          stab_state_r <= stab; first_r <= 1'b0;
          prev_f_r <= freq_r; prev_c_r <= beat_r.count; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/frequency_rocof_stability_monitor_core.sv =====
// ----------------------------------------------------------------------------
// frequency_rocof_stability_monitor_core: frequency / ROCOF stability monitor
// Period counts in, frequency, rate of change and a stability verdict out.
// ----------------------------------------------------------------------------
// Each in beat (period count, timestamp) yields one out beat. Frequency is
// Fs*256/count, rate is |f-f_prev|*2*Fs/(count+count_prev), both Q.8 and
// saturating; count 0 counts as 1. The first beat after reset is stable with
// rate 0. From leaving the queue to its out beat, a beat is popped, passes
// one shared bit-serial divider (41 quotient bits) for the frequency, starts
// the rate division with diff*Fs and passes the divider again (skipped for
// the first beat after reset), then waits for room on the out side and loads
// the out register. The 2-entry input queue keeps accepting while it has
// room and the back end works. Write configuration only while idle.
`default_nettype none
module frequency_rocof_stability_monitor_core import frmon_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CountBits-1:0] in_period_count,
  input  wire logic [TsBits-1:0]    in_timestamp,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_stable,
  output logic                      out_stability_changed,
  output logic [FreqBits-1:0]       out_frequency_q8,
  output logic [RateBits-1:0]       out_rocof_q8,
  output logic [TsBits-1:0]         out_event_time,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [RateBits-1:0]  cfg_data
);
  logic [FsBits-1:0]   fs_r;
  logic [FreqBits-1:0] low_r, high_r;
  logic [RateBits-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FsReset; low_r <= LowReset; high_r <= HighReset; lim_r <= RateReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFs:   fs_r   <= cfg_data[FsBits-1:0];
        RegLow:  low_r  <= cfg_data[FreqBits-1:0];
        RegHigh: high_r <= cfg_data[FreqBits-1:0];
        RegRate: lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic        q_valid, q_pop;
  frmon_beat_t q_beat;

  frmon_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_period_count(in_period_count), .in_timestamp(in_timestamp),
    .q_valid(q_valid), .q_pop(q_pop), .q_beat(q_beat)
  );

  frmon_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_beat(q_beat),
    .fs(fs_r), .f_low(low_r), .f_high(high_r), .r_limit(lim_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_stable(out_stable),
    .out_stability_changed(out_stability_changed),
    .out_frequency_q8(out_frequency_q8), .out_rocof_q8(out_rocof_q8),
    .out_event_time(out_event_time)
  );
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: frequency / ROCOF stability monitor core
// Directed table plus random period counts across register settings; every
// out beat is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import frmon_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CountBits-1:0] in_period_count = '0;
  logic [TsBits-1:0]    in_timestamp = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_stable;
  logic                 out_stability_changed;
  logic [FreqBits-1:0]  out_frequency_q8;
  logic [RateBits-1:0]  out_rocof_q8;
  logic [TsBits-1:0]    out_event_time;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = RegFs;
  logic [RateBits-1:0]  cfg_data = '0;

  frequency_rocof_stability_monitor_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one expected out beat
  typedef struct {
    logic                stable;
    logic                changed;
    logic [FreqBits-1:0] freq;
    logic [RateBits-1:0] rate;
    logic [TsBits-1:0]   ts;
  } verdict_t;

  verdict_t pending_verdicts[$];
  int       errors = 0;

  // predictor copy of registers and state
  logic [FsBits-1:0]    fs_hz;
  logic [FreqBits-1:0]  low_q8, high_q8;
  logic [RateBits-1:0]  rate_lim_q8;
  logic [FreqBits-1:0]  last_freq;
  logic [CountBits-1:0] last_count;
  logic                 last_stable, awaiting_first;

  logic in_idle_on = 1'b1;
  logic out_idle_on = 1'b1;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // frequency, rate and verdict for one count; advances predictor state
  function automatic verdict_t predict_beat(input logic [CountBits-1:0] cnt_in,
                                            input logic [TsBits-1:0] ts);
    verdict_t   v;
    logic [63:0] cnt, f, diff, den, r;
    logic        st;
    cnt = (cnt_in == 0) ? 64'd1 : 64'(cnt_in);
    f = (64'(fs_hz) << FracBits) / cnt;
    if (f > 64'hFF_FFFF) f = 64'hFF_FFFF;
    r = 0;
    if (awaiting_first) begin
      st = 1'b1;
    end else begin
      diff = (f >= 64'(last_freq)) ? f - 64'(last_freq) : 64'(last_freq) - f;
      den = cnt + 64'(last_count);
      if (den == 0) den = 1;
      r = (diff * 64'(fs_hz) * 2) / den;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      st = (f > 64'(low_q8)) && (f < 64'(high_q8)) && (r < 64'(rate_lim_q8));
    end
    v.stable = st;
    v.changed = (st != last_stable);
    v.freq = f[FreqBits-1:0];
    v.rate = r[RateBits-1:0];
    v.ts = ts;
    last_stable = st;
    last_freq = f[FreqBits-1:0];
    last_count = cnt[CountBits-1:0];
    awaiting_first = 1'b0;
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [RateBits-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      RegFs:   fs_hz = val[FsBits-1:0];
      RegLow:  low_q8 = val[FreqBits-1:0];
      RegHigh: high_q8 = val[FreqBits-1:0];
      default: rate_lim_q8 = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up from one beat to the next unless an idle cycle is drawn
  task automatic send_beat(input logic [CountBits-1:0] cnt, input logic [TsBits-1:0] ts);
    while (in_idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_period_count <= cnt;
    in_timestamp <= ts;
    pending_verdicts.push_back(predict_beat(cnt, ts));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // result side: random stalls, checked against the oldest expectation
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("unexpected beat", 64'd0, 64'd0);
        end else begin
          v = pending_verdicts.pop_front();
          if (out_stable !== v.stable)
            report_mismatch("stable", 64'(out_stable), 64'(v.stable));
          if (out_stability_changed !== v.changed)
            report_mismatch("changed", 64'(out_stability_changed), 64'(v.changed));
          if (out_frequency_q8 !== v.freq)
            report_mismatch("freq", 64'(out_frequency_q8), 64'(v.freq));
          if (out_rocof_q8 !== v.rate)
            report_mismatch("rocof", 64'(out_rocof_q8), 64'(v.rate));
          if (out_event_time !== v.ts)
            report_mismatch("time", 64'(out_event_time), 64'(v.ts));
        end
      end
      out_ready <= !(out_idle_on && $urandom_range(99) < 9);
    end
  end

  // directed rows: count, timestamp, and a typed expectation where obvious
  typedef struct {
    logic [CountBits-1:0] cnt;
    logic [TsBits-1:0]    ts;
    logic                 known;
    logic [FreqBits-1:0]  freq;
    logic [RateBits-1:0]  rate;
  } row_t;

  localparam int NumRows = 12;
  row_t rows[NumRows] = '{
    '{16'd320,   32'h0000_0000, 1'b1, 24'd12800, 32'd0},   // first beat: rate 0
    '{16'd320,   32'hFFFF_FFFF, 1'b1, 24'd12800, 32'd0},   // steady 50 Hz
    '{16'd0,     32'h8000_0001, 1'b0, 24'd0, 32'd0},       // zero count taken as one
    '{16'd1,     32'h7FFF_FFFE, 1'b1, 24'd4096000, 32'd0}, // same top frequency again
    '{16'hFFFF,  32'h1234_5678, 1'b0, 24'd0, 32'd0},
    '{16'd330,   32'h0000_0010, 1'b0, 24'd0, 32'd0},
    '{16'd300,   32'h0000_0020, 1'b0, 24'd0, 32'd0},
    '{16'd327,   32'h0000_0030, 1'b0, 24'd0, 32'd0},       // near low limit
    '{16'd291,   32'h0000_0040, 1'b0, 24'd0, 32'd0},       // near high limit
    '{16'd320,   32'h0000_0050, 1'b0, 24'd0, 32'd0},
    '{16'hAAAA,  32'hAAAA_AAAA, 1'b0, 24'd0, 32'd0},
    '{16'h5555,  32'h5555_5555, 1'b0, 24'd0, 32'd0}
  };

  task automatic random_phase(input int n);
    logic [CountBits-1:0] base, c;
    for (int i = 0; i < n; i++) begin
      base = (i % 40 == 0) ? 16'($urandom_range(200, 400)) : base;
      case ($urandom_range(9))
        0:       c = 16'($urandom);                      // noise
        1:       c = 16'($urandom_range(3));
        default: c = base + 16'($urandom_range(6)) - 16'd3;
      endcase
      send_beat(c, $urandom);
    end
  endtask

  initial begin
    verdict_t v;
    fs_hz = FsReset; low_q8 = LowReset; high_q8 = HighReset; rate_lim_q8 = RateReset;
    last_freq = '0; last_count = '0; last_stable = 1'b1; awaiting_first = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      send_beat(rows[i].cnt, rows[i].ts);
      v = pending_verdicts[$];
      if (rows[i].known && (v.freq !== rows[i].freq || v.rate !== rows[i].rate))
        report_mismatch("table row", 64'(i), 64'(v.freq));
    end
    // hold off until the block has caught up
    drain_and_settle();

    // no-idle stretch at reset-value registers
    in_idle_on = 1'b0; out_idle_on = 1'b0;
    random_phase(80);
    in_idle_on = 1'b1; out_idle_on = 1'b1;
    drain_and_settle();

    write_reg(RegFs, 32'd65535);
    write_reg(RegLow, 32'd0);
    write_reg(RegHigh, 32'hFF_FFFF);
    write_reg(RegRate, 32'hFFFF_FFFF);
    random_phase(120);
    drain_and_settle();

    write_reg(RegFs, 32'd1);
    write_reg(RegLow, 32'hFF_FFFF);
    write_reg(RegHigh, 32'd0);
    write_reg(RegRate, 32'd0);
    random_phase(60);
    drain_and_settle();

    write_reg(RegFs, 32'd0);
    random_phase(30);
    drain_and_settle();

    write_reg(RegFs, 32'd16000);
    write_reg(RegLow, 32'd12544);
    write_reg(RegHigh, 32'd14080);
    write_reg(RegRate, 32'h0001_0000);
    random_phase(130);
    drain_and_settle();

    write_reg(RegFs, 32'h0000_AAAA);
    write_reg(RegLow, 32'h00_5555);
    write_reg(RegHigh, 32'hAA_AAAA);
    write_reg(RegRate, 32'h5555_5555);
    random_phase(120);
    drain_and_settle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog: bounds the run of ~560 beats
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
